/* sv/multi_pipe_fifo_table_macros.svh */
// assertion macros for the pipe table
`ifndef MULTI_PIPE_FIFO_TABLE_MACROS_SVH
`define MULTI_PIPE_FIFO_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while in reset
`define MPFT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpft assertion failed");
// next-cycle implication, sampled on clk, off while in reset
`define MPFT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpft assertion failed");
`else
`define MPFT_ASSERT_NOW(label, ante, cons)
`define MPFT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/mpft_pkg.sv */
package mpft_pkg;

	// table geometry
	localparam int NUM_PIPES = 8;
	localparam int BUF_BYTES = 64;
	localparam int MEM_DEPTH = NUM_PIPES * BUF_BYTES;

	// derived widths
	localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int IDX_W  = $clog2(BUF_BYTES);
	localparam int CNT_W  = $clog2(BUF_BYTES + 1);
	localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// port field widths
	localparam int OP_W    = 3;
	localparam int ID_W    = 4;
	localparam int BYTE_W  = 8;
	localparam int STAT_W  = 3;
	localparam int GRANT_W = 3;
	localparam int OCNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_OPEN  = 3'd0,
		OP_CLOSE = 3'd1,
		OP_SEND  = 3'd2,
		OP_RECV  = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 3'd0,
		STAT_BAD   = 3'd1,
		STAT_NONE  = 3'd2,
		STAT_FULL  = 3'd3,
		STAT_EMPTY = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// operation held for the execute cycle
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	// result fields produced by the execute cycle
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [GRANT_W-1:0] granted_pipe;
		logic [BYTE_W-1:0]  data_out;
		logic [OCNT_W-1:0]  used_count;
		logic [OCNT_W-1:0]  free_space;
		logic               is_open;
	} res_t;

	// flat byte address of a position inside a pipe's buffer
	function automatic logic [ADDR_W-1:0] byte_addr(input logic [PIPE_W-1:0] pipe,
			input logic [IDX_W-1:0] idx);
		byte_addr = ADDR_W'(pipe) * ADDR_W'(BUF_BYTES) + ADDR_W'(idx);
	endfunction

	// ring position advance
	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		next_pos = (p == IDX_W'(BUF_BYTES - 1)) ? '0 : p + IDX_W'(1);
	endfunction

endpackage

/* sv/mpft_byte_ram.sv */
module mpft_byte_ram (
	input  logic                              clk,
	input  logic                              we,
	input  logic [mpft_pkg::ADDR_W-1:0]       waddr,
	input  logic [mpft_pkg::BYTE_W-1:0]       wdata,
	input  logic                              re,
	input  logic [mpft_pkg::ADDR_W-1:0]       raddr,
	output logic [mpft_pkg::BYTE_W-1:0]       rdata
);

	logic [mpft_pkg::BYTE_W-1:0] mem [mpft_pkg::MEM_DEPTH];
	logic [mpft_pkg::BYTE_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/mpft_pipe_table.sv */
module mpft_pipe_table (
	input  logic                              clk,
	input  logic                              arst_n,
	// lookup at accept time
	input  logic                              lk_en,
	input  logic [mpft_pkg::ID_W-1:0]         lk_id,
	output logic [mpft_pkg::ADDR_W-1:0]       rd_addr,
	// execute
	input  logic                              fire,
	input  mpft_pkg::cmd_t                    cmd,
	input  logic [mpft_pkg::BYTE_W-1:0]       rdata,
	output logic                              wr_en,
	output logic [mpft_pkg::ADDR_W-1:0]       wr_addr,
	output mpft_pkg::res_t                    res
);

	logic                         open_q   [mpft_pkg::NUM_PIPES];
	logic [mpft_pkg::IDX_W-1:0]   wr_idx_q [mpft_pkg::NUM_PIPES];
	logic [mpft_pkg::IDX_W-1:0]   rd_idx_q [mpft_pkg::NUM_PIPES];
	logic [mpft_pkg::CNT_W-1:0]   fill_q   [mpft_pkg::NUM_PIPES];
	logic [mpft_pkg::IDX_W-1:0]   rd_idx_s1;

	logic [mpft_pkg::PIPE_W-1:0]  lk_sel;
	logic                         valid;
	logic [mpft_pkg::PIPE_W-1:0]  sel;
	logic                         opened;
	logic [mpft_pkg::CNT_W-1:0]   cnt;
	logic [mpft_pkg::IDX_W-1:0]   wi;
	logic                         found;
	logic [mpft_pkg::PIPE_W-1:0]  free_idx;
	logic [mpft_pkg::CNT_W-1:0]   used;
	logic [mpft_pkg::CNT_W-1:0]   space;
	logic                         do_open;
	logic                         do_close;
	logic                         do_push;
	logic                         do_pop;

	// read position lookup for the byte memory
	assign lk_sel = (int'(lk_id) < mpft_pkg::NUM_PIPES)
		? lk_id[mpft_pkg::PIPE_W-1:0] : '0;
	assign rd_addr = mpft_pkg::byte_addr(lk_sel, rd_idx_q[lk_sel]);

	always_ff @(posedge clk) begin
		if (lk_en) begin
			rd_idx_s1 <= rd_idx_q[lk_sel];
		end
	end

	// addressed pipe in the execute cycle
	assign valid  = int'(cmd.id) < mpft_pkg::NUM_PIPES;
	assign sel    = valid ? cmd.id[mpft_pkg::PIPE_W-1:0] : '0;
	assign opened = valid && open_q[sel];
	assign cnt    = fill_q[sel];
	assign wi     = wr_idx_q[sel];

	// lowest-numbered free pipe
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = mpft_pkg::NUM_PIPES - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				found    = 1'b1;
				free_idx = mpft_pkg::PIPE_W'(i);
			end
		end
	end

	// operation decode and result
	always_comb begin
		res      = '0;
		res.status = mpft_pkg::STAT_BAD;
		used     = '0;
		space    = '0;
		do_open  = 1'b0;
		do_close = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		unique case (mpft_pkg::op_t'(cmd.op))
			mpft_pkg::OP_OPEN: begin
				res.status = mpft_pkg::STAT_NONE;
				if (found) begin
					do_open          = 1'b1;
					res.status       = mpft_pkg::STAT_OK;
					res.granted_pipe = mpft_pkg::GRANT_W'(free_idx);
					res.is_open      = 1'b1;
					space            = mpft_pkg::CNT_W'(mpft_pkg::BUF_BYTES);
				end
			end
			mpft_pkg::OP_CLOSE: begin
				if (opened) begin
					do_close   = 1'b1;
					res.status = mpft_pkg::STAT_OK;
					space      = mpft_pkg::CNT_W'(mpft_pkg::BUF_BYTES);
				end
			end
			mpft_pkg::OP_SEND: begin
				if (opened) begin
					res.is_open = 1'b1;
					if (cnt == mpft_pkg::CNT_W'(mpft_pkg::BUF_BYTES)) begin
						res.status = mpft_pkg::STAT_FULL;
						used       = cnt;
					end else begin
						do_push    = 1'b1;
						res.status = mpft_pkg::STAT_OK;
						used       = cnt + mpft_pkg::CNT_W'(1);
					end
					space = mpft_pkg::CNT_W'(mpft_pkg::BUF_BYTES) - used;
				end
			end
			mpft_pkg::OP_RECV: begin
				if (opened) begin
					res.is_open = 1'b1;
					if (cnt == '0) begin
						res.status = mpft_pkg::STAT_EMPTY;
						used       = cnt;
					end else begin
						do_pop       = 1'b1;
						res.status   = mpft_pkg::STAT_OK;
						res.data_out = rdata;
						used         = cnt - mpft_pkg::CNT_W'(1);
					end
					space = mpft_pkg::CNT_W'(mpft_pkg::BUF_BYTES) - used;
				end
			end
			mpft_pkg::OP_QUERY: begin
				if (valid) begin
					res.status = mpft_pkg::STAT_OK;
					if (opened) begin
						res.is_open = 1'b1;
						used        = cnt;
						space       = mpft_pkg::CNT_W'(mpft_pkg::BUF_BYTES) - cnt;
					end
				end
			end
			default: begin
				res.status = mpft_pkg::STAT_BAD;
			end
		endcase
		res.used_count = mpft_pkg::OCNT_W'(used);
		res.free_space = mpft_pkg::OCNT_W'(space);
	end

	// byte store write for a successful send
	assign wr_en   = fire && do_push;
	assign wr_addr = mpft_pkg::byte_addr(sel, wi);

	// pointer and flag updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpft_pkg::NUM_PIPES; i++) begin
				open_q[i]   <= 1'b0;
				wr_idx_q[i] <= '0;
				rd_idx_q[i] <= '0;
				fill_q[i]   <= '0;
			end
		end else if (fire) begin
			if (do_open) begin
				open_q[free_idx]   <= 1'b1;
				wr_idx_q[free_idx] <= '0;
				rd_idx_q[free_idx] <= '0;
				fill_q[free_idx]   <= '0;
			end
			if (do_close) begin
				open_q[sel]   <= 1'b0;
				wr_idx_q[sel] <= '0;
				rd_idx_q[sel] <= '0;
				fill_q[sel]   <= '0;
			end
			if (do_push) begin
				wr_idx_q[sel] <= mpft_pkg::next_pos(wi);
				fill_q[sel]   <= cnt + mpft_pkg::CNT_W'(1);
			end
			if (do_pop) begin
				rd_idx_q[sel] <= mpft_pkg::next_pos(rd_idx_s1);
				fill_q[sel]   <= cnt - mpft_pkg::CNT_W'(1);
			end
		end
	end

endmodule

/* sv/multi_pipe_fifo_table.sv */
// Table of 8 byte pipes, each a 64-byte ring FIFO; every accepted item gives
// exactly one result. Open takes the lowest-numbered free pipe, close frees
// one, send and receive push and pop one byte, query reports fill and space.
// An item has an accept cycle and an execute cycle: the accept cycle looks up the pipe's read position
// and starts the registered read of the byte memory, the execute cycle
// updates the pointer table, writes a sent byte and loads the output
// register. The block takes a new item in the cycle after execute and none
// while an item is in flight; a held result stops the execute cycle until
// the output register frees. No clearing pass
// runs after reset. Receiving a byte that was never sent is impossible in
// normal use, since a pipe's fill count only covers bytes written since open.
`include "multi_pipe_fifo_table_macros.svh"

module multi_pipe_fifo_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mpft_pkg::OP_W-1:0]         op,
	input  logic [mpft_pkg::ID_W-1:0]         pipe_id,
	input  logic [mpft_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              msg_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mpft_pkg::STAT_W-1:0]       status,
	output logic [mpft_pkg::GRANT_W-1:0]      granted_pipe,
	output logic [mpft_pkg::BYTE_W-1:0]       data_out,
	output logic [mpft_pkg::OCNT_W-1:0]       used_count,
	output logic [mpft_pkg::OCNT_W-1:0]       free_space,
	output logic                              is_open,
	output logic                              msg_end
);

	mpft_pkg::state_t                state_q;
	mpft_pkg::state_t                state_d;
	mpft_pkg::cmd_t                  cmd_q;
	logic                            last_q;
	logic                            accept;
	logic                            fire;
	logic [mpft_pkg::ADDR_W-1:0]     rd_addr;
	logic [mpft_pkg::BYTE_W-1:0]     rdata;
	logic                            wr_en;
	logic [mpft_pkg::ADDR_W-1:0]     wr_addr;
	mpft_pkg::res_t                  res;
	logic                            out_valid_q;
	mpft_pkg::res_t                  res_q;
	logic                            msg_end_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpft_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = mpft_pkg::S_EXEC;
				end
			end
			mpft_pkg::S_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = mpft_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpft_pkg::S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		fire     = 1'b0;
		unique case (state_q)
			mpft_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			mpft_pkg::S_EXEC: begin
				fire = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpft_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op   <= op;
			cmd_q.id   <= pipe_id;
			cmd_q.data <= data_byte;
			last_q     <= msg_last;
		end
	end

	mpft_pipe_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.lk_en   (accept),
		.lk_id   (pipe_id),
		.rd_addr (rd_addr),
		.fire    (fire),
		.cmd     (cmd_q),
		.rdata   (rdata),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.res     (res)
	);

	mpft_byte_ram u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (cmd_q.data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q     <= res;
			msg_end_q <= last_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign granted_pipe = res_q.granted_pipe;
	assign data_out     = res_q.data_out;
	assign used_count   = res_q.used_count;
	assign free_space   = res_q.free_space;
	assign is_open      = res_q.is_open;
	assign msg_end      = msg_end_q;

	// one item in flight: no accept right after an accept
	`MPFT_ASSERT_NEXT(a_one_in_flight, accept, !in_ready)
	// a new result only comes out of the execute cycle
	`MPFT_ASSERT_NOW(a_result_from_exec, $rose(out_valid_q), $past(state_q == mpft_pkg::S_EXEC))
	// an open pipe's fill and free space add up to the buffer size
	`MPFT_ASSERT_NOW(a_fill_space_sum, out_valid_q && res_q.is_open,
		mpft_pkg::OCNT_W'(res_q.used_count + res_q.free_space)
			== mpft_pkg::OCNT_W'(mpft_pkg::BUF_BYTES))

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	// one result as the pipe table should give it
	typedef struct {
		mpft_pkg::status_t            status;
		logic [mpft_pkg::GRANT_W-1:0] granted;
		logic [mpft_pkg::BYTE_W-1:0]  data;
		logic [mpft_pkg::OCNT_W-1:0]  used;
		logic [mpft_pkg::OCNT_W-1:0]  space;
		logic                         opened;
		logic                         last;
	} pipe_result_t;

	// shadow copy of the pipe table and the results still owed
	class pipe_shadow;
		bit                          open_flag[mpft_pkg::NUM_PIPES];
		logic [mpft_pkg::BYTE_W-1:0] store[mpft_pkg::NUM_PIPES][mpft_pkg::BUF_BYTES];
		logic [mpft_pkg::IDX_W-1:0]  wr_pos[mpft_pkg::NUM_PIPES];
		logic [mpft_pkg::IDX_W-1:0]  rd_pos[mpft_pkg::NUM_PIPES];
		logic [mpft_pkg::CNT_W-1:0]  fill[mpft_pkg::NUM_PIPES];
		pipe_result_t                due[$];
		int                          mismatches;

		function new();
			for (int i = 0; i < mpft_pkg::NUM_PIPES; i++) begin
				open_flag[i] = 1'b0;
				wr_pos[i] = '0;
				rd_pos[i] = '0;
				fill[i] = '0;
			end
			mismatches = 0;
		endfunction

		function logic [mpft_pkg::IDX_W-1:0] ring_step(logic [mpft_pkg::IDX_W-1:0] pos);
			return (pos == mpft_pkg::IDX_W'(mpft_pkg::BUF_BYTES - 1)) ? '0 : pos + 1'b1;
		endfunction

		// apply one accepted item and queue the result it owes
		function void note_item(logic [mpft_pkg::OP_W-1:0] code,
				logic [mpft_pkg::ID_W-1:0] id, logic [mpft_pkg::BYTE_W-1:0] din,
				logic last);
			pipe_result_t r;
			int p;
			int i;
			bit id_ok;
			bit live;
			r.status = mpft_pkg::STAT_BAD;
			r.granted = '0;
			r.data = '0;
			r.used = '0;
			r.space = '0;
			r.opened = 1'b0;
			r.last = last;
			id_ok = (id < mpft_pkg::NUM_PIPES);
			p = id_ok ? int'(id) : 0;
			live = id_ok && open_flag[p];
			case (code)
			mpft_pkg::OP_OPEN: begin
				r.status = mpft_pkg::STAT_NONE;
				for (i = 0; i < mpft_pkg::NUM_PIPES; i++) begin
					if (!open_flag[i]) begin
						open_flag[i] = 1'b1;
						wr_pos[i] = '0;
						rd_pos[i] = '0;
						fill[i] = '0;
						r.status = mpft_pkg::STAT_OK;
						r.granted = mpft_pkg::GRANT_W'(i);
						r.space = mpft_pkg::OCNT_W'(mpft_pkg::BUF_BYTES);
						r.opened = 1'b1;
						break;
					end
				end
			end
			mpft_pkg::OP_CLOSE: begin
				if (live) begin
					open_flag[p] = 1'b0;
					wr_pos[p] = '0;
					rd_pos[p] = '0;
					fill[p] = '0;
					r.status = mpft_pkg::STAT_OK;
					r.space = mpft_pkg::OCNT_W'(mpft_pkg::BUF_BYTES);
				end
			end
			mpft_pkg::OP_SEND: begin
				if (live) begin
					r.opened = 1'b1;
					if (fill[p] >= mpft_pkg::BUF_BYTES) begin
						r.status = mpft_pkg::STAT_FULL;
					end else begin
						store[p][wr_pos[p]] = din;
						wr_pos[p] = ring_step(wr_pos[p]);
						fill[p] = fill[p] + 1'b1;
						r.status = mpft_pkg::STAT_OK;
					end
					r.used = mpft_pkg::OCNT_W'(fill[p]);
					r.space = mpft_pkg::OCNT_W'(mpft_pkg::BUF_BYTES - fill[p]);
				end
			end
			mpft_pkg::OP_RECV: begin
				if (live) begin
					r.opened = 1'b1;
					if (fill[p] == 0) begin
						r.status = mpft_pkg::STAT_EMPTY;
					end else begin
						r.data = store[p][rd_pos[p]];
						rd_pos[p] = ring_step(rd_pos[p]);
						fill[p] = fill[p] - 1'b1;
						r.status = mpft_pkg::STAT_OK;
					end
					r.used = mpft_pkg::OCNT_W'(fill[p]);
					r.space = mpft_pkg::OCNT_W'(mpft_pkg::BUF_BYTES - fill[p]);
				end
			end
			mpft_pkg::OP_QUERY: begin
				if (id_ok) begin
					r.status = mpft_pkg::STAT_OK;
					if (live) begin
						r.opened = 1'b1;
						r.used = mpft_pkg::OCNT_W'(fill[p]);
						r.space = mpft_pkg::OCNT_W'(mpft_pkg::BUF_BYTES - fill[p]);
					end
				end
			end
			default: begin
			end
			endcase
			due.push_back(r);
		endfunction

		function void flag(string field, int want, logic [mpft_pkg::BYTE_W-1:0] got);
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
			mismatches++;
		endfunction

		// compare one delivered result with the oldest one owed
		function void check_result(logic [mpft_pkg::STAT_W-1:0] st,
				logic [mpft_pkg::GRANT_W-1:0] gr, logic [mpft_pkg::BYTE_W-1:0] dout,
				logic [mpft_pkg::OCNT_W-1:0] used, logic [mpft_pkg::OCNT_W-1:0] space,
				logic opn, logic mend);
			pipe_result_t r;
			if (due.size() == 0) begin
				$display("%0t: result with none owed, status expected none got %0d",
					$time, st);
				mismatches++;
				return;
			end
			r = due.pop_front();
			if (st !== r.status) flag("status", r.status, st);
			if (gr !== r.granted) flag("granted_pipe", r.granted, gr);
			if (dout !== r.data) flag("data_out", r.data, dout);
			if (used !== r.used) flag("used_count", r.used, used);
			if (space !== r.space) flag("free_space", r.space, space);
			if (opn !== r.opened) flag("is_open", r.opened, opn);
			if (mend !== r.last) flag("msg_end", r.last, mend);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [mpft_pkg::OP_W-1:0] op = '0;
	logic [mpft_pkg::ID_W-1:0] pipe_id = '0;
	logic [mpft_pkg::BYTE_W-1:0] data_byte = '0;
	logic msg_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [mpft_pkg::STAT_W-1:0] status;
	logic [mpft_pkg::GRANT_W-1:0] granted_pipe;
	logic [mpft_pkg::BYTE_W-1:0] data_out;
	logic [mpft_pkg::OCNT_W-1:0] used_count;
	logic [mpft_pkg::OCNT_W-1:0] free_space;
	logic is_open;
	logic msg_end;

	pipe_shadow pipes;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asks = 0;
	int issued = 0;
	int unsigned cycles = 0;

	multi_pipe_fifo_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.pipe_id(pipe_id),
		.data_byte(data_byte),
		.msg_last(msg_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_pipe(granted_pipe),
		.data_out(data_out),
		.used_count(used_count),
		.free_space(free_space),
		.is_open(is_open),
		.msg_end(msg_end)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_pipe_fifo_table: mismatch");
			$finish;
		end
	end

	// offer one item, with random idle cycles ahead of it
	task automatic put_item(input logic [mpft_pkg::OP_W-1:0] code, input int id,
			input int din, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		pipe_id <= mpft_pkg::ID_W'(id);
		data_byte <= mpft_pkg::BYTE_W'(din);
		msg_last <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pipes.note_item(code, mpft_pkg::ID_W'(id), mpft_pkg::BYTE_W'(din), last);
		issued++;
	endtask

	// stop offering until every owed result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pipes.due.size() != 0) @(posedge clk);
	endtask

	// random open pipe, or -1 when none is open
	function automatic int open_pick();
		int start;
		int k;
		start = $urandom_range(mpft_pkg::NUM_PIPES - 1);
		for (k = 0; k < mpft_pkg::NUM_PIPES; k++) begin
			if (pipes.open_flag[(start + k) % mpft_pkg::NUM_PIPES])
				return (start + k) % mpft_pkg::NUM_PIPES;
		end
		return -1;
	endfunction

	// one short sequence: mostly messages in and out of open pipes, some noise
	task automatic random_burst();
		int kind;
		int p;
		int n;
		int k;
		kind = $urandom_range(99);
		p = open_pick();
		if (kind < 6) begin
			put_item(mpft_pkg::OP_W'($urandom_range(7)), $urandom_range(15),
				$urandom_range(255), $urandom_range(1));
		end else if (p < 0 || kind < 14) begin
			// churn: free a pipe now and then, then claim one
			if (p >= 0 && $urandom_range(3) != 0)
				put_item(mpft_pkg::OP_CLOSE, p, $urandom_range(255), $urandom_range(1));
			put_item(mpft_pkg::OP_OPEN, $urandom_range(15), $urandom_range(255),
				$urandom_range(1));
		end else if (kind < 20) begin
			put_item(mpft_pkg::OP_QUERY, $urandom_range(15), $urandom_range(255),
				$urandom_range(1));
		end else if (kind < 58) begin
			// message into one pipe, once in a while run it past full
			if ($urandom_range(23) == 0) n = mpft_pkg::BUF_BYTES - pipes.fill[p] + 2;
			else n = $urandom_range(8, 1);
			for (k = 0; k < n; k++)
				put_item(mpft_pkg::OP_SEND, p, $urandom_range(255), k == n - 1);
		end else begin
			// read a message back, sometimes past empty
			if ($urandom_range(9) == 0) n = pipes.fill[p] + 2;
			else n = $urandom_range(8, 1);
			for (k = 0; k < n; k++)
				put_item(mpft_pkg::OP_RECV, p, $urandom_range(255), k == n - 1);
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		int target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = issued + count;
		while (issued < target) random_burst();
		drain();
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				pipes.check_result(status, granted_pipe, data_out, used_count, free_space,
					is_open, msg_end);
			if (hold_asks != hold_seen) begin
				hold_left = HOLD_CYCLES;
				hold_seen = hold_asks;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// item side: reset, directed items, random phases, end check
	initial begin
		int k;
		pipes = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// closed and out-of-range pipes before anything is open
		put_item(mpft_pkg::OP_QUERY, 0, 0, 0);
		put_item(mpft_pkg::OP_CLOSE, 3, 0, 1);
		put_item(mpft_pkg::OP_SEND, 2, 8'h5A, 0);
		put_item(mpft_pkg::OP_RECV, 2, 0, 1);
		put_item(mpft_pkg::OP_QUERY, 15, 8'hFF, 1);
		put_item(mpft_pkg::OP_SEND, 8, 8'hFF, 0);
		// unused op codes
		for (k = 5; k < 8; k++) put_item(mpft_pkg::OP_W'(k), k, 8'hC3, k[0]);
		// claim every pipe, then one more with none free
		for (k = 0; k <= mpft_pkg::NUM_PIPES; k++) put_item(mpft_pkg::OP_OPEN, 15 - k, 0, 0);
		// byte extremes through pipe 0, then past empty
		put_item(mpft_pkg::OP_SEND, 0, 8'h00, 0);
		put_item(mpft_pkg::OP_SEND, 0, 8'hFF, 1);
		put_item(mpft_pkg::OP_QUERY, 0, 0, 0);
		put_item(mpft_pkg::OP_RECV, 0, 0, 0);
		put_item(mpft_pkg::OP_RECV, 0, 0, 1);
		put_item(mpft_pkg::OP_RECV, 0, 0, 0);
		// free the top pipe and claim it back
		put_item(mpft_pkg::OP_CLOSE, mpft_pkg::NUM_PIPES - 1, 0, 0);
		put_item(mpft_pkg::OP_OPEN, 0, 0, 1);
		drain();

		// random phases over the idle and stall mixes
		run_phase(0, 0, 230);
		run_phase(49, 0, 210);
		run_phase(0, 49, 210);
		run_phase(23, 23, 210);
		// long receiver hold-off while items keep coming, so the input stalls
		hold_asks++;
		run_phase(0, 0, 60);

		repeat (8) @(posedge clk);
		if (pipes.mismatches == 0 && pipes.due.size() == 0)
			$display("multi_pipe_fifo_table: match");
		else
			$display("multi_pipe_fifo_table: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/mpft_pkg.sv
sv/mpft_byte_ram.sv
sv/mpft_pipe_table.sv
sv/multi_pipe_fifo_table.sv
tb/tb_top.sv
